// File: rtl/core/sirt_pkg.sv
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared types and constants of the signed integer to radix text converter.
// ----------------------------------------------------------------------------
package sirt_pkg;

  localparam int unsigned DEF_MAX_SYMBOLS = 16;
  localparam int unsigned DEF_VALUE_BITS  = 32;

  localparam int unsigned ALPHA_LEN   = 16;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned SYM_IDX_W   = 4;
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA_LO  = 2'd0,
    REG_ALPHA_HI  = 2'd1,
    REG_SYM_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic [ALPHA_LEN-1:0][SYM_W-1:0] sym;
    logic [COUNT_W-1:0]              radix;
  } cfg_t;

endpackage

// File: rtl/core/signed_int_to_radix_text_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_text_top
// Converts signed integers to text in a configured radix, one character per
// result item.
// ----------------------------------------------------------------------------
// Items enter a two-entry queue and are converted one at a time. The divider
// takes one byte of the magnitude per cycle; each digit takes one pass over
// the significant bytes of the remaining quotient, the first over all
// ceil(VALUE_BITS/8) bytes. The characters then leave one per cycle, while
// the output is popped, from the digit stack through the output register.
// An item arriving while the alphabet is unusable is dropped at the input
// and yields no characters.
// ----------------------------------------------------------------------------
module signed_int_to_radix_text_top #(
  parameter int unsigned MAX_SYMBOLS = sirt_pkg::DEF_MAX_SYMBOLS,
  parameter int unsigned VALUE_BITS  = sirt_pkg::DEF_VALUE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic signed [VALUE_BITS-1:0]   value_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [sirt_pkg::SYM_W-1:0]     symbol_o,
  output logic                           last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sirt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sirt_pkg::CFG_W-1:0]     cfg_data_i
);
  import sirt_pkg::*;

  localparam int unsigned RAD_W   = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned ENTRY_W = 1 + RAD_W + VALUE_BITS;

  cfg_t               cfg;
  logic               q_full;
  logic               q_push;
  logic [ENTRY_W-1:0] q_wdata;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_rdata;
  logic               q_empty;

  sirt_cfg #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sirt_front #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .push_i  (push),
    .full_o  (full),
    .value_i (value_i),
    .cfg_i   (cfg),
    .q_full_i(q_full),
    .q_push_o(q_push),
    .q_data_o(q_wdata)
  );

  sirt_fifo #(
    .WIDTH(ENTRY_W)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  sirt_back #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_data_i (q_rdata),
    .q_pop_o  (q_pop),
    .cfg_i    (cfg),
    .empty_o  (empty),
    .pop_i    (pop),
    .symbol_o (symbol_o),
    .last_o   (last_o)
  );

endmodule

// File: rtl/core/sirt_cfg.sv
// ----------------------------------------------------------------------------
// sirt_cfg
// Configuration registers and alphabet check; yields the radix, zero if the
// alphabet is unusable.
// ----------------------------------------------------------------------------
module sirt_cfg #(
  parameter int unsigned MAX_SYMBOLS = sirt_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sirt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sirt_pkg::CFG_W-1:0]     cfg_data_i,
  output sirt_pkg::cfg_t                 cfg_o
);
  import sirt_pkg::*;

  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_SYMBOLS);

  logic [CFG_W-1:0]                alpha_lo_q;
  logic [CFG_W-1:0]                alpha_hi_q;
  logic [COUNT_W-1:0]              count_q;
  logic [ALPHA_LEN-1:0][SYM_W-1:0] sym;
  logic [COUNT_W-1:0]              limit;
  logic [COUNT_W-1:0]              n_used;
  logic                            alpha_ok;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_lo_q <= '0;
      alpha_hi_q <= '0;
      count_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ALPHA_LO:  alpha_lo_q <= cfg_data_i;
        REG_ALPHA_HI:  alpha_hi_q <= cfg_data_i;
        REG_SYM_COUNT: count_q    <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign sym   = {alpha_hi_q, alpha_lo_q};
  assign limit = (count_q > MAX_CNT) ? MAX_CNT : count_q;

  always_comb begin
    n_used = limit;
    for (int i = ALPHA_LEN - 1; i >= 0; i--) begin
      if ((COUNT_W'(i) < limit) && (sym[i] == '0)) begin
        n_used = COUNT_W'(i);
      end
    end
  end

  always_comb begin
    alpha_ok = (n_used >= COUNT_W'(2));
    for (int i = 0; i < ALPHA_LEN; i++) begin
      if (COUNT_W'(i) < n_used) begin
        if ((sym[i] == CHAR_PLUS) || (sym[i] == CHAR_MINUS)) begin
          alpha_ok = 1'b0;
        end
        for (int j = 0; j < i; j++) begin
          if (sym[i] == sym[j]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  assign cfg_o.sym   = sym;
  assign cfg_o.radix = alpha_ok ? n_used : '0;

endmodule

// File: rtl/core/sirt_front.sv
// ----------------------------------------------------------------------------
// sirt_front
// Input side: splits each value into sign and magnitude, tags it with the
// radix and drops it when the alphabet is unusable.
// ----------------------------------------------------------------------------
module sirt_front #(
  parameter  int unsigned MAX_SYMBOLS = sirt_pkg::DEF_MAX_SYMBOLS,
  parameter  int unsigned VALUE_BITS  = sirt_pkg::DEF_VALUE_BITS,
  localparam int unsigned RAD_W       = $clog2(MAX_SYMBOLS + 1),
  localparam int unsigned ENTRY_W     = 1 + RAD_W + VALUE_BITS
) (
  input  logic                         push_i,
  output logic                         full_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  sirt_pkg::cfg_t               cfg_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output logic [ENTRY_W-1:0]           q_data_o
);
  import sirt_pkg::*;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic                  radix_ok;

  assign raw      = value_i;
  assign neg      = raw[VALUE_BITS-1];
  assign mag      = neg ? VALUE_BITS'(~raw + 1'b1) : raw;
  assign radix_ok = (cfg_i.radix != '0);

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i && radix_ok;
  assign q_data_o = {neg, RAD_W'(cfg_i.radix), mag};

endmodule

// File: rtl/core/sirt_fifo.sv
// ----------------------------------------------------------------------------
// sirt_fifo
// Short queue between the input side and the conversion engine.
// ----------------------------------------------------------------------------
module sirt_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import sirt_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/sirt_back.sv
// ----------------------------------------------------------------------------
// sirt_back
// Conversion engine: divides the magnitude by the radix one byte per cycle,
// stacks the digits and emits the text most significant digit first.
// ----------------------------------------------------------------------------
module sirt_back #(
  parameter  int unsigned MAX_SYMBOLS = sirt_pkg::DEF_MAX_SYMBOLS,
  parameter  int unsigned VALUE_BITS  = sirt_pkg::DEF_VALUE_BITS,
  localparam int unsigned RAD_W       = $clog2(MAX_SYMBOLS + 1),
  localparam int unsigned ENTRY_W     = 1 + RAD_W + VALUE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  logic [ENTRY_W-1:0]         q_data_i,
  output logic                       q_pop_o,
  input  sirt_pkg::cfg_t             cfg_i,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic [sirt_pkg::SYM_W-1:0] symbol_o,
  output logic                       last_o
);
  import sirt_pkg::*;

  localparam int unsigned DIG_W = $clog2(MAX_SYMBOLS);
  localparam int unsigned PW    = DIG_W + 1;
  localparam int unsigned NB    = (VALUE_BITS + 7) / 8;
  localparam int unsigned BIW   = (NB > 1) ? $clog2(NB) : 1;
  localparam int unsigned AW    = $clog2(VALUE_BITS);
  localparam int unsigned CW    = $clog2(VALUE_BITS + 1);

  back_state_e          state_q, state_d;
  logic [NB-1:0][7:0]   mag_q;
  logic [BIW-1:0]       bi_q;
  logic [BIW-1:0]       hi_q;
  logic                 seen_q;
  logic [DIG_W-1:0]     rem_q;
  logic [RAD_W-1:0]     radix_q;
  logic                 neg_q;
  logic [CW-1:0]        wp_q, wp_d;
  logic                 sign_q, sign_d;
  logic                 pend_q, pend_d;
  logic                 pend_last_q;
  logic [DIG_W-1:0]     rd_q;
  logic                 out_valid_q, out_valid_d;
  logic [SYM_W-1:0]     out_sym_q;
  logic                 out_last_q;
  logic [DIG_W-1:0]     mem [VALUE_BITS];

  logic [VALUE_BITS-1:0] in_mag;
  logic [RAD_W-1:0]      in_radix;
  logic                  in_neg;
  logic [7:0]            byte_in;
  logic [7:0]            qb;
  logic [DIG_W-1:0]      div_rem;
  logic                  seen_now;
  logic [BIW-1:0]        hi_now;
  logic                  last_byte;
  logic                  load;
  logic                  pop_ok;
  logic                  out_free;
  logic                  consume;
  logic                  load_sign;
  logic                  issue;
  logic [CW-1:0]         wp_m1;
  logic [AW-1:0]         rd_addr;

  assign {in_neg, in_radix, in_mag} = q_data_i;

  assign byte_in   = mag_q[bi_q];
  assign last_byte = (bi_q == '0);

  always_comb begin
    logic [PW-1:0]    part;
    logic [DIG_W-1:0] r;
    r  = rem_q;
    qb = '0;
    for (int k = 7; k >= 0; k--) begin
      part = {r, byte_in[k]};
      if (part >= PW'(radix_q)) begin
        qb[k] = 1'b1;
        r     = DIG_W'(part - PW'(radix_q));
      end else begin
        r = part[DIG_W-1:0];
      end
    end
    div_rem = r;
  end

  assign seen_now = seen_q || (qb != '0);
  assign hi_now   = (!seen_q && (qb != '0)) ? bi_q : hi_q;

  assign pop_ok    = pop_i && out_valid_q;
  assign out_free  = !out_valid_q || pop_ok;
  assign load_sign = out_free && sign_q;
  assign consume   = out_free && pend_q && !sign_q;
  assign wp_m1     = wp_q - CW'(1);
  assign rd_addr   = wp_m1[AW-1:0];

  always_comb begin
    state_d     = state_q;
    q_pop_o     = 1'b0;
    load        = 1'b0;
    issue       = 1'b0;
    wp_d        = wp_q;
    sign_d      = sign_q && !load_sign;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          load    = 1'b1;
          wp_d    = '0;
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        if (last_byte) begin
          wp_d = wp_q + CW'(1);
          if (!seen_now) begin
            sign_d  = neg_q;
            state_d = B_EMIT;
          end
        end
      end
      B_EMIT: begin
        if ((wp_q != '0) && (!pend_q || consume)) begin
          issue = 1'b1;
          wp_d  = wp_m1;
        end
        if ((wp_q == '0) && !pend_q && !sign_q) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign pend_d      = issue || (pend_q && !consume);
  assign out_valid_d = load_sign || consume || (out_valid_q && !pop_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      wp_q        <= '0;
      sign_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      sign_q      <= sign_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mag_q   <= (NB * 8)'(in_mag);
      bi_q    <= BIW'(NB - 1);
      hi_q    <= '0;
      seen_q  <= 1'b0;
      rem_q   <= '0;
      radix_q <= in_radix;
      neg_q   <= in_neg;
    end else if (state_q == B_DIV) begin
      mag_q[bi_q] <= qb;
      if (last_byte) begin
        bi_q   <= hi_now;
        hi_q   <= '0;
        seen_q <= 1'b0;
        rem_q  <= '0;
      end else begin
        bi_q   <= bi_q - 1'b1;
        hi_q   <= hi_now;
        seen_q <= seen_now;
        rem_q  <= div_rem;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == B_DIV) && last_byte) begin
      mem[wp_q[AW-1:0]] <= div_rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q        <= mem[rd_addr];
      pend_last_q <= (rd_addr == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_sign) begin
      out_sym_q  <= CHAR_MINUS;
      out_last_q <= 1'b0;
    end else if (consume) begin
      out_sym_q  <= cfg_i.sym[SYM_IDX_W'(rd_q)];
      out_last_q <= pend_last_q;
    end
  end

  assign empty_o  = !out_valid_q;
  assign symbol_o = out_sym_q;
  assign last_o   = out_last_q;

  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> (PW'(rem_q) < PW'(radix_q)))
    else $error("remainder not below radix");

  a_last_digit_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && pend_last_q) |-> (wp_q == '0))
    else $error("digits left after final digit");

  a_sign_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sign_q |-> (state_q == B_EMIT))
    else $error("sign pending outside emit");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= CW'(VALUE_BITS))
    else $error("digit stack overflow");

  a_emit_empty_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == B_EMIT) && (state_d == B_IDLE)) |-> !pend_q && !sign_q)
    else $error("leaving emit with characters pending");

endmodule

// File: bench/signed_int_to_radix_text_top_test.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_text_top_test
// Self-checking bench for the signed integer to radix text converter.
// ----------------------------------------------------------------------------
// A driver takes integers and register writes from a job queue and offers
// them to the converter. Each accepted integer is expanded into the characters
// it should produce, using a local copy of the alphabet registers and the
// validity rules. A monitor pops characters with random stalls and checks
// each one against the oldest outstanding character. Alphabet changes are
// only made once the converter has drained and had time to settle. A short
// directed set covers the value extremes and every alphabet corner case,
// then random alphabets and values follow.
// ----------------------------------------------------------------------------
module signed_int_to_radix_text_top_test;
  import sirt_pkg::*;

  localparam int unsigned VBITS          = DEF_VALUE_BITS;
  localparam int unsigned NSYM           = DEF_MAX_SYMBOLS;
  localparam int unsigned ABITS          = ALPHA_LEN * SYM_W;
  localparam int unsigned SETTLE_CYCLES  = 160;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned HOLD_AT_FIRST  = 250;
  localparam int unsigned HOLD_AT_SECOND = 1200;
  localparam int unsigned CYCLE_LIMIT    = 4_000_000;
  localparam int unsigned RANDOM_ITEMS   = 320;
  localparam int unsigned REPORT_LIMIT   = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [ABITS-1:0]     DIGITS    = {64'h6665_6463_6261_3938,
                                                64'h3736_3534_3332_3130};
  localparam logic [VBITS-1:0]     VALUE_MIN = {1'b1, {(VBITS-1){1'b0}}};
  localparam logic [VBITS-1:0]     VALUE_MAX = {1'b0, {(VBITS-1){1'b1}}};

  typedef enum logic [1:0] {JOB_VALUE, JOB_WRITE, JOB_DRAIN} job_kind_e;
  typedef enum int {FLAW_NONE, FLAW_ZERO, FLAW_REPEAT, FLAW_PLUS, FLAW_MINUS} flaw_e;

  typedef struct {
    job_kind_e            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } job_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } char_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    push        = 1'b0;
  logic                    full;
  logic signed [VBITS-1:0] value_i     = '0;
  logic                    empty;
  logic                    pop         = 1'b0;
  logic [SYM_W-1:0]        symbol_o;
  logic                    last_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_W-1:0]        cfg_data_i  = '0;

  logic [ABITS-1:0]   alphabet_m = '0;
  logic [COUNT_W-1:0] count_m    = '0;

  job_t        stim_jobs[$];
  char_t       due_chars[$];
  int unsigned mismatches  = 0;
  int unsigned chars_seen  = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  int unsigned settle      = 0;
  bit          steady      = 1'b0;
  bit          all_sent    = 1'b0;

  signed_int_to_radix_text_top #(
    .MAX_SYMBOLS(NSYM),
    .VALUE_BITS (VBITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .value_i    (value_i),
    .empty      (empty),
    .pop        (pop),
    .symbol_o   (symbol_o),
    .last_o     (last_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [SYM_W-1:0] glyph(int unsigned i);
    return alphabet_m[SYM_W*i +: SYM_W];
  endfunction

  function automatic int unsigned usable_radix();
    int unsigned limit;
    int unsigned n;
    limit = 32'(count_m);
    n = 0;
    if (limit > NSYM) limit = NSYM;
    if (limit > ALPHA_LEN) limit = ALPHA_LEN;
    while (n < limit && glyph(n) != '0) n++;
    if (n < 2) return 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (glyph(i) == CHAR_PLUS || glyph(i) == CHAR_MINUS) return 0;
      for (int unsigned j = 0; j < i; j++)
        if (glyph(j) == glyph(i)) return 0;
    end
    return n;
  endfunction

  function automatic void predict_text(logic [VBITS-1:0] v);
    int unsigned      radix;
    logic [VBITS-1:0] mag;
    int unsigned      digits[$];
    radix = usable_radix();
    if (radix == 0) return;
    mag = v[VBITS-1] ? (~v + 1'b1) : v;
    do begin
      digits.push_front(mag % radix);
      mag = mag / radix;
    end while (mag != 0);
    if (v[VBITS-1]) due_chars.push_back(char_t'{CHAR_MINUS, 1'b0});
    foreach (digits[k])
      due_chars.push_back(char_t'{glyph(digits[k]), k == digits.size() - 1});
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endfunction

  function automatic logic [ABITS-1:0] random_alphabet(int unsigned used, flaw_e flaw);
    logic [ABITS-1:0] a;
    logic [SYM_W-1:0] s;
    bit               fresh;
    int unsigned      span;
    int unsigned      p;
    int unsigned      q;
    a = '0;
    for (int unsigned i = 0; i < ALPHA_LEN; i++) begin
      do begin
        s = SYM_W'($urandom_range(1, 255));
        fresh = (s != CHAR_PLUS) && (s != CHAR_MINUS);
        for (int unsigned j = 0; j < i; j++)
          if (a[SYM_W*j +: SYM_W] == s) fresh = 1'b0;
      end while (!fresh);
      a[SYM_W*i +: SYM_W] = s;
    end
    span = (used > ALPHA_LEN) ? ALPHA_LEN : ((used < 2) ? 2 : used);
    p = $urandom_range(0, span - 2);
    q = $urandom_range(p + 1, span - 1);
    case (flaw)
      FLAW_ZERO:   a[SYM_W*q +: SYM_W] = '0;
      FLAW_REPEAT: a[SYM_W*q +: SYM_W] = a[SYM_W*p +: SYM_W];
      FLAW_PLUS:   a[SYM_W*q +: SYM_W] = CHAR_PLUS;
      FLAW_MINUS:  a[SYM_W*p +: SYM_W] = CHAR_MINUS;
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [VBITS-1:0] random_value();
    logic [VBITS-1:0] v;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20);
      1: return -VBITS'($urandom_range(1, 20));
      2: return VALUE_MIN + $urandom_range(0, 3);
      3: return VALUE_MAX - $urandom_range(0, 3);
      4: begin
        v = $urandom >> $urandom_range(1, VBITS - 1);
        return $urandom_range(0, 1) ? -v : v;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_value(logic [VBITS-1:0] v);
    stim_jobs.push_back('{kind: JOB_VALUE, index: '0, data: CFG_W'(v)});
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    stim_jobs.push_back('{kind: JOB_WRITE, index: idx, data: d});
  endfunction

  function automatic void add_drain();
    stim_jobs.push_back('{kind: JOB_DRAIN, index: '0, data: '0});
  endfunction

  function automatic void add_alphabet(logic [ABITS-1:0] a, logic [CFG_W-1:0] count_word);
    add_write(REG_ALPHA_LO, a[CFG_W-1:0]);
    add_write(REG_ALPHA_HI, a[2*CFG_W-1:CFG_W]);
    add_write(REG_SYM_COUNT, count_word);
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count % 512 == 0) steady <= ($urandom_range(0, 3) == 0);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    bit took_item;
    bit took_write;
    bit next_push;
    bit next_cfg;
    if (!rst_ni) begin
      push        <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      took_item  = push && !full;
      took_write = cfg_valid_i && cfg_ready_o;
      next_push  = push && !took_item;
      next_cfg   = cfg_valid_i && !took_write;
      if (took_item) predict_text(value_i);
      if (took_write) begin
        case (cfg_index_i)
          REG_ALPHA_LO:  alphabet_m[CFG_W-1:0]       = cfg_data_i;
          REG_ALPHA_HI:  alphabet_m[2*CFG_W-1:CFG_W] = cfg_data_i;
          REG_SYM_COUNT: count_m                     = cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (took_item || due_chars.size() != 0) settle = 0;
      else if (settle < SETTLE_CYCLES) settle++;
      if (!next_push && !next_cfg) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (stim_jobs.size() == 0) begin
          all_sent = 1'b1;
        end else if (stim_jobs[0].kind == JOB_VALUE) begin
          value_i   <= stim_jobs[0].data[VBITS-1:0];
          next_push = 1'b1;
          gap_left  = pick_gap();
          void'(stim_jobs.pop_front());
        end else if (settle >= SETTLE_CYCLES) begin
          if (stim_jobs[0].kind == JOB_WRITE) begin
            cfg_index_i <= stim_jobs[0].index;
            cfg_data_i  <= stim_jobs[0].data;
            next_cfg    = 1'b1;
          end
          void'(stim_jobs.pop_front());
        end
      end
      push        <= next_push;
      cfg_valid_i <= next_cfg;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    char_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        chars_seen++;
        if (due_chars.size() == 0) begin
          flag_mismatch($sformatf("unexpected symbol %02h last %0b", symbol_o, last_o));
        end else begin
          want = due_chars.pop_front();
          if (symbol_o !== want.symbol || last_o !== want.last)
            flag_mismatch($sformatf("symbol %02h last %0b, expected symbol %02h last %0b",
                                    symbol_o, last_o, want.symbol, want.last));
        end
        if (chars_seen == HOLD_AT_FIRST || chars_seen == HOLD_AT_SECOND)
          hold_left = HOLD_CYCLES;
        else
          stall_left = pick_gap();
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    logic [ABITS-1:0] alpha;
    logic [CFG_W-1:0] word;
    int unsigned      used;
    int unsigned      count;
    int unsigned      taken;
    flaw_e            flaw;

    // reset alphabet is unusable: drop both
    add_value(5);
    add_value(-5);
    add_write(REG_SPARE, {$urandom, $urandom});

    add_alphabet(DIGITS, 10);
    add_value(0);
    add_value(1);
    add_value(-1);
    add_value(VALUE_MAX);
    add_value(VALUE_MIN);
    add_value(10);
    add_value(-10);
    add_value(987654321);
    add_drain();

    add_write(REG_SYM_COUNT, 2);
    add_value(VALUE_MIN);
    add_value(VALUE_MAX);
    add_value(-1);
    add_value(0);

    add_write(REG_SYM_COUNT, 16);
    add_value(32'hDEAD_BEEF);
    add_value(VALUE_MIN);
    add_value(255);

    // oversized count clamps to the full alphabet
    add_write(REG_SYM_COUNT, {CFG_W{1'b1}});
    add_value(-1);

    alpha = DIGITS;
    alpha[SYM_W*3 +: SYM_W] = '0;
    add_alphabet(alpha, 10);
    add_value(100);
    add_value(VALUE_MIN);

    alpha = DIGITS;
    alpha[SYM_W*1 +: SYM_W] = '0;
    add_alphabet(alpha, 10);
    add_value(7);

    alpha = DIGITS;
    alpha[SYM_W*5 +: SYM_W] = alpha[SYM_W*1 +: SYM_W];
    add_alphabet(alpha, 10);
    add_value(7);

    alpha = DIGITS;
    alpha[0 +: SYM_W] = CHAR_PLUS;
    add_alphabet(alpha, 10);
    add_value(7);

    alpha = DIGITS;
    alpha[SYM_W*9 +: SYM_W] = CHAR_MINUS;
    add_alphabet(alpha, 16);
    add_value(7);

    add_alphabet(DIGITS, 1);
    add_value(7);

    add_alphabet({ABITS{1'b1}}, 0);
    add_value(3);

    taken = 0;
    while (taken < RANDOM_ITEMS) begin
      used  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
      flaw  = ($urandom_range(0, 4) == 0) ? flaw_e'($urandom_range(1, 4)) : FLAW_NONE;
      alpha = random_alphabet(used, flaw);
      word  = {$urandom, $urandom};
      word[COUNT_W-1:0] = COUNT_W'(used);
      add_alphabet(alpha, word);
      count = (flaw == FLAW_NONE && used >= 2) ? $urandom_range(15, 40) : $urandom_range(3, 6);
      for (int unsigned i = 0; i < count; i++) begin
        add_value(random_value());
        if ($urandom_range(0, 59) == 0) add_drain();
      end
      if (flaw == FLAW_NONE && used >= 2) taken += count;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(all_sent && due_chars.size() == 0)) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_chars.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
